// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; each macro samples on the rising edge and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a property on every edge outside reset.
`define LNKQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Hold a consequent in the cycle after an antecedent.
`define LNKQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lnkq_pkg.sv =====
// Shared constants, operation codes and types of the linked thread queue.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package lnkq_pkg;
  localparam int SLOTS_DEF   = 16;
  localparam int SLOT_FW     = 4;
  localparam int COUNT_FW    = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic append_ok;
    logic remove_ok;
  } lnkq_status_t;
endpackage
`default_nettype wire

// ===== rtl/lnkq_link_ram.sv =====
// One link table: one write and one registered read per cycle.
// Depends on lnkq_pkg; the read register forwards a write to the same address.
`default_nettype none
module lnkq_link_ram #(
  parameter int SLOTS = lnkq_pkg::SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(SLOTS)-1:0] waddr,
  input  wire logic [$clog2(SLOTS)-1:0] wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(SLOTS)-1:0] raddr,
  output logic      [$clog2(SLOTS)-1:0] rdata_r
);
  import lnkq_pkg::*;

  localparam int SW = $clog2(SLOTS);

  logic [SW-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lnkq_update.sv =====
// Next-state logic for one queue operation: checks, pointer and link updates.
// Depends on lnkq_pkg; purely combinational, fed by the stage and pointer registers.
`default_nettype none
module lnkq_update #(
  parameter int SLOTS = lnkq_pkg::SLOTS_DEF
) (
  input  wire logic                       op,
  input  wire logic [$clog2(SLOTS)-1:0]   slot_idx,
  input  wire logic                       slot_ok,
  input  wire logic                       slot_member,
  input  wire logic [$clog2(SLOTS)-1:0]   next_rd,
  input  wire logic [$clog2(SLOTS)-1:0]   prev_rd,
  input  wire logic [$clog2(SLOTS)-1:0]   head,
  input  wire logic [$clog2(SLOTS)-1:0]   tail,
  input  wire logic [$clog2(SLOTS+1)-1:0] count,
  output logic      [$clog2(SLOTS)-1:0]   head_nxt,
  output logic      [$clog2(SLOTS)-1:0]   tail_nxt,
  output logic      [$clog2(SLOTS+1)-1:0] count_nxt,
  output logic                            next_we,
  output logic      [$clog2(SLOTS)-1:0]   next_waddr,
  output logic      [$clog2(SLOTS)-1:0]   next_wdata,
  output logic                            prev_we,
  output logic      [$clog2(SLOTS)-1:0]   prev_waddr,
  output logic      [$clog2(SLOTS)-1:0]   prev_wdata,
  output lnkq_pkg::lnkq_status_t          status
);
  import lnkq_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic          is_head;
  logic          is_tail;
  logic [SW-1:0] succ;
  logic [SW-1:0] pred;

  // Tail's next and head's prev are implied by the circular order.
  assign is_head = (slot_idx == head);
  assign is_tail = (slot_idx == tail);
  assign succ    = is_tail ? head : next_rd;
  assign pred    = is_head ? tail : prev_rd;

  always_comb begin
    status.append_ok = slot_ok && (op == OP_APPEND) && !slot_member && (count < CW'(SLOTS));
    status.remove_ok = slot_ok && (op == OP_REMOVE) && slot_member && (count != '0);
    head_nxt   = head;
    tail_nxt   = tail;
    count_nxt  = count;
    next_we    = 1'b0;
    next_waddr = tail;
    next_wdata = slot_idx;
    prev_we    = 1'b0;
    prev_waddr = slot_idx;
    prev_wdata = tail;
    if (status.append_ok) begin
      count_nxt = count + CW'(1);
      tail_nxt  = slot_idx;
      if (count == '0) begin
        head_nxt = slot_idx;
      end else begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
    end else if (status.remove_ok) begin
      count_nxt = count - CW'(1);
      if (count == CW'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else begin
        next_we    = 1'b1;
        next_waddr = pred;
        next_wdata = succ;
        prev_we    = 1'b1;
        prev_waddr = succ;
        prev_wdata = pred;
        if (is_head) begin
          head_nxt = succ;
        end
        if (is_tail) begin
          tail_nxt = pred;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/linked_thread_queue.sv =====
// Linked thread queue: ready-queue manager over a pool of thread slots.
// Depends on lnkq_pkg, lnkq_link_ram and lnkq_update.
//
// Input channel in_*: one transaction is one operation. in_tuser carries the
// opcode (append at tail or remove), in_tdata the slot index.
// Result channel out_*: one transaction per operation, in order, giving head,
// tail, count, empty flag and error flag after the operation.
// Two register stages, the input stage and the result register; one operation
// is taken every cycle while the receiver does not stall. The link tables are
// read as an operation enters the input stage, and the write of the operation
// in the update stage is forwarded into that read, so back-to-back operations
// on linked slots work.
// Reset empties the list at once: membership bits, head, tail and count clear;
// the link tables need no clearing since a stale entry is never used.
// When the receiver stalls, the result register holds, the input stage fills
// and then in_tready drops; no transaction is lost or repeated.
`default_nettype none
module linked_thread_queue #(
  parameter int SLOTS = lnkq_pkg::SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [3:0] slot, [7:4] zero
  input  wire logic [lnkq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  wire logic [lnkq_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [3:0] head_slot, [7:4] tail_slot, [12:8] node_count, [13] list_empty,
  // [14] op_error, [15] zero
  output logic      [lnkq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lnkq_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic               a_v_r;
  logic               a_op_r;
  logic [SLOT_FW-1:0] a_slot_r;
  logic [SW-1:0]      next_rd_r;
  logic [SW-1:0]      prev_rd_r;

  logic [SW-1:0]      head_r;
  logic [SW-1:0]      tail_r;
  logic [CW-1:0]      count_r;
  logic [SLOTS-1:0]   member_r;

  logic               out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic               in_fire;
  logic               b_fire;
  logic [SW-1:0]      rd_idx;
  logic [SW-1:0]      slot_idx;
  logic               slot_ok;
  logic               slot_member;

  logic [SW-1:0]      head_nxt;
  logic [SW-1:0]      tail_nxt;
  logic [CW-1:0]      count_nxt;
  logic               next_we;
  logic [SW-1:0]      next_waddr;
  logic [SW-1:0]      next_wdata;
  logic               prev_we;
  logic [SW-1:0]      prev_waddr;
  logic [SW-1:0]      prev_wdata;
  lnkq_status_t       status;

  logic               nxt_empty;
  logic               we_next;
  logic               we_prev;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  assign b_fire    = a_v_r && (!out_v_r || out_tready);
  assign in_tready = !a_v_r || b_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign rd_idx      = SW'(in_tdata[SLOT_FW-1:0]);
  assign slot_idx    = SW'(a_slot_r);
  assign slot_ok     = (32'(a_slot_r) < 32'(SLOTS));
  assign slot_member = slot_ok && member_r[slot_idx];

  assign we_next = b_fire && next_we;
  assign we_prev = b_fire && prev_we;

  lnkq_link_ram #(.SLOTS(SLOTS)) u_next_ram (
    .clk     (clk),
    .we      (we_next),
    .waddr   (next_waddr),
    .wdata   (next_wdata),
    .re      (in_fire),
    .raddr   (rd_idx),
    .rdata_r (next_rd_r)
  );

  lnkq_link_ram #(.SLOTS(SLOTS)) u_prev_ram (
    .clk     (clk),
    .we      (we_prev),
    .waddr   (prev_waddr),
    .wdata   (prev_wdata),
    .re      (in_fire),
    .raddr   (rd_idx),
    .rdata_r (prev_rd_r)
  );

  lnkq_update #(.SLOTS(SLOTS)) u_update (
    .op          (a_op_r),
    .slot_idx    (slot_idx),
    .slot_ok     (slot_ok),
    .slot_member (slot_member),
    .next_rd     (next_rd_r),
    .prev_rd     (prev_rd_r),
    .head        (head_r),
    .tail        (tail_r),
    .count       (count_r),
    .head_nxt    (head_nxt),
    .tail_nxt    (tail_nxt),
    .count_nxt   (count_nxt),
    .next_we     (next_we),
    .next_waddr  (next_waddr),
    .next_wdata  (next_wdata),
    .prev_we     (prev_we),
    .prev_waddr  (prev_waddr),
    .prev_wdata  (prev_wdata),
    .status      (status)
  );

  assign nxt_empty = (count_nxt == '0);

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[3:0]   = nxt_empty ? 4'd0 : 4'(head_nxt);
    out_data_nxt[7:4]   = nxt_empty ? 4'd0 : 4'(tail_nxt);
    out_data_nxt[12:8]  = COUNT_FW'(count_nxt);
    out_data_nxt[13]    = nxt_empty;
    out_data_nxt[14]    = !(status.append_ok || status.remove_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      out_v_r  <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      member_r <= '0;
    end else begin
      if (in_fire) begin
        a_v_r <= 1'b1;
      end else if (b_fire) begin
        a_v_r <= 1'b0;
      end
      if (b_fire) begin
        out_v_r <= 1'b1;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
        if (status.append_ok) begin
          member_r[slot_idx] <= 1'b1;
        end else if (status.remove_ok) begin
          member_r[slot_idx] <= 1'b0;
        end
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op_r   <= in_tuser[0];
      a_slot_r <= in_tdata[SLOT_FW-1:0];
    end
    if (b_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

// ===== rtl/lnkq_checker.sv =====
// Port-level checks of the linked thread queue result channel.
// Depends on lnkq_pkg and assert_macros.svh; bound to linked_thread_queue.
`default_nettype none
`include "assert_macros.svh"
module lnkq_checker #(
  parameter int SLOTS = lnkq_pkg::SLOTS_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [lnkq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lnkq_pkg::*;

  `LNKQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `LNKQ_ASSERT(a_empty_flag, clk, rst_n, !out_tvalid || (out_tdata[13] == (out_tdata[12:8] == 5'd0)), "empty flag disagrees with count")
  `LNKQ_ASSERT(a_empty_ptrs, clk, rst_n, !out_tvalid || !out_tdata[13] || (out_tdata[7:0] == 8'd0), "empty list reports non-zero head or tail")
  `LNKQ_ASSERT(a_count_max, clk, rst_n, !out_tvalid || (32'(out_tdata[12:8]) <= 32'(SLOTS)), "count exceeds pool size")
endmodule

bind linked_thread_queue lnkq_checker #(.SLOTS(SLOTS)) u_lnkq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for linked_thread_queue: appends and removals on the slot list,
// results checked in order against a local linked-list predictor.
// Depends on lnkq_pkg and the linked_thread_queue RTL only.
module tb_top;
  import lnkq_pkg::*;

  localparam int N_SLOTS     = SLOTS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                op_error;
    logic                list_empty;
    logic [COUNT_FW-1:0] node_count;
    logic [SLOT_FW-1:0]  tail_slot;
    logic [SLOT_FW-1:0]  head_slot;
  } queue_status_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [SLOT_FW-1:0]  ll_next [N_SLOTS];
  logic [SLOT_FW-1:0]  ll_prev [N_SLOTS];
  logic                ll_member [N_SLOTS];
  logic [SLOT_FW-1:0]  ll_head  = '0;
  logic [SLOT_FW-1:0]  ll_tail  = '0;
  logic [COUNT_FW-1:0] ll_count = '0;

  queue_status_t pending_status[$];

  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  int long_hold_len = 0;
  int ops_sent      = 0;
  int ops_rejected  = 0;
  int peak_count    = 0;
  int mismatch_cnt  = 0;
  int quiet_cycles  = 0;

  linked_thread_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      ll_next[i]   = '0;
      ll_prev[i]   = '0;
      ll_member[i] = 1'b0;
    end
  end

  function automatic queue_status_t apply_list_op(logic op, logic [SLOT_FW-1:0] s);
    logic               ok;
    logic [SLOT_FW-1:0] n;
    logic [SLOT_FW-1:0] p;
    queue_status_t      r;
    ok = 1'b0;
    if (op == OP_APPEND) begin
      if (!ll_member[s] && ll_count < N_SLOTS) begin
        ok = 1'b1;
        if (ll_count == 0) begin
          ll_next[s] = s;
          ll_prev[s] = s;
          ll_head    = s;
        end else begin
          ll_prev[s]       = ll_tail;
          ll_next[s]       = ll_head;
          ll_next[ll_tail] = s;
          ll_prev[ll_head] = s;
        end
        ll_tail      = s;
        ll_member[s] = 1'b1;
        ll_count     = ll_count + 1'b1;
      end
    end else if (ll_count != 0 && ll_member[s]) begin
      ok           = 1'b1;
      ll_member[s] = 1'b0;
      if (ll_count == 1) begin
        ll_head = '0;
        ll_tail = '0;
      end else begin
        n          = ll_next[s];
        p          = ll_prev[s];
        ll_next[p] = n;
        ll_prev[n] = p;
        if (s == ll_head) ll_head = n;
        if (s == ll_tail) ll_tail = p;
      end
      ll_count = ll_count - 1'b1;
    end
    r.head_slot  = (ll_count == 0) ? '0 : ll_head;
    r.tail_slot  = (ll_count == 0) ? '0 : ll_tail;
    r.node_count = ll_count;
    r.list_empty = (ll_count == 0);
    r.op_error   = !ok;
    return r;
  endfunction

  function automatic logic [SLOT_FW-1:0] pick_slot(logic want_member);
    logic [SLOT_FW-1:0] s;
    do s = SLOT_FW'($urandom_range(0, N_SLOTS - 1)); while (ll_member[s] != want_member);
    return s;
  endfunction

  task automatic send_op(logic op, logic [SLOT_FW-1:0] s);
    int            gap;
    queue_status_t st;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - SLOT_FW){1'b0}}, s};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    st = apply_list_op(op, s);
    pending_status.push_back(st);
    ops_sent++;
    if (st.op_error) ops_rejected++;
    if (int'(st.node_count) > peak_count) peak_count = int'(st.node_count);
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      send_op(1'($urandom_range(0, 1)), SLOT_FW'($urandom_range(0, N_SLOTS - 1)));
    else if (ll_count == 0 || (ll_count < N_SLOTS && r < 57))
      send_op(OP_APPEND, pick_slot(1'b0));
    else
      send_op(OP_REMOVE, pick_slot(1'b1));
  endtask

  task automatic drain_list();
    while (ll_count != 0) send_op(OP_REMOVE, pick_slot(1'b1));
  endtask

  task automatic test_empty_errors();
    send_op(OP_REMOVE, 4'd0);
    send_op(OP_REMOVE, 4'd15);
  endtask

  task automatic test_single_slot();
    send_op(OP_APPEND, 4'd0);
    send_op(OP_APPEND, 4'd0);
    send_op(OP_REMOVE, 4'd5);
    send_op(OP_REMOVE, 4'd0);
  endtask

  task automatic test_head_tail_middle();
    send_op(OP_APPEND, 4'd15);
    send_op(OP_APPEND, 4'd3);
    send_op(OP_APPEND, 4'd7);
    send_op(OP_APPEND, 4'd9);
    send_op(OP_REMOVE, 4'd3);
    send_op(OP_REMOVE, 4'd15);
    send_op(OP_REMOVE, 4'd9);
    send_op(OP_APPEND, 4'd3);
    send_op(OP_REMOVE, 4'd7);
    send_op(OP_REMOVE, 4'd3);
  endtask

  task automatic test_full_pool();
    drain_list();
    while (ll_count < N_SLOTS) send_op(OP_APPEND, pick_slot(1'b0));
    send_op(OP_APPEND, SLOT_FW'($urandom_range(0, N_SLOTS - 1)));
    drain_list();
  endtask

  task automatic test_backpressure();
    tx_idle_en    = 1'b0;
    long_hold_len = 80;
    repeat (30) random_op();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_mix(int n_ops);
    for (int i = 0; i < n_ops; i++) begin
      tx_idle_en = (i % 75) < 60;
      rx_idle_en = (i % 75) < 60;
      random_op();
    end
  endtask

  task automatic test_quiet_tail(int n_ops);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (n_ops) random_op();
  endtask

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (long_hold_len) @(posedge clk);
        long_hold_len = 0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    queue_status_t got;
    queue_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(queue_status_t)-1:0];
      if (pending_status.size() == 0) begin
        note_mismatch($sformatf("unexpected result tdata=%h", out_tdata));
      end else begin
        want = pending_status.pop_front();
        if (got.head_slot !== want.head_slot || got.tail_slot !== want.tail_slot ||
            got.node_count !== want.node_count || got.list_empty !== want.list_empty ||
            got.op_error !== want.op_error)
          note_mismatch($sformatf(
            "head %0d/%0d tail %0d/%0d count %0d/%0d empty %0b/%0b err %0b/%0b (exp/act)",
            want.head_slot, got.head_slot, want.tail_slot, got.tail_slot,
            want.node_count, got.node_count, want.list_empty, got.list_empty,
            want.op_error, got.op_error));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout, %0d results outstanding", $realtime, pending_status.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_errors();
    test_single_slot();
    test_head_tail_middle();
    test_full_pool();
    test_backpressure();
    test_random_mix(300);
    test_quiet_tail(40);
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d list operations, %0d rejected as illegal, occupancy up to %0d of %0d.",
             ops_sent, ops_rejected, peak_count, N_SLOTS);
    $display("Result mismatches: %0d, results outstanding: %0d.",
             mismatch_cnt, pending_status.size());
    if (mismatch_cnt == 0 && pending_status.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
